>>> rtl/ip_cidr_access_check_macros.svh
// ----------------------------------------------------------------------------
// IP CIDR access check assertion macros
// Shared assertion forms for the access check block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IP_CIDR_ACCESS_CHECK_MACROS_SVH
`define IP_CIDR_ACCESS_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPACL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ipacl_pkg.sv
// ----------------------------------------------------------------------------
// IP CIDR access check package
// Field layouts, codes and types shared by the access check block.
// ----------------------------------------------------------------------------
package ipacl_pkg;

    localparam int RULES       = 7;
    localparam int RULE_WORDS  = 7;
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 6;
    localparam int RULE_W      = 42;
    localparam int MODE_W      = 2;
    localparam int CLASS_W     = 2;
    localparam int VERDICT_W   = 2;
    localparam int HIT_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;

    localparam int ADDR_LSB    = 0;
    localparam int PLEN_LSB    = 32;
    localparam int DIR_LSB     = 38;
    localparam int KIND_LSB    = 40;

    localparam logic [HIT_W-1:0] NO_HIT = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_SECURITY_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_BASE     = 3'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_DISABLED   = 2'd0,
        MODE_NO_RULES   = 2'd1,
        MODE_RULES      = 2'd2,
        MODE_RULES_ALT  = 2'd3
    } sec_mode_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_UNKNOWN = 2'd0,
        CLASS_PLAY    = 2'd1,
        CLASS_PUBLISH = 2'd2,
        CLASS_INVALID = 2'd3
    } conn_class_t;

    localparam logic [1:0] DIR_PLAY    = 2'd0;
    localparam logic [1:0] DIR_PUBLISH = 2'd1;

    localparam logic [1:0] KIND_ALLOW  = 2'd1;
    localparam logic [1:0] KIND_DENY   = 2'd2;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ALLOW        = 2'd0,
        VERDICT_DENY_RULE    = 2'd1,
        VERDICT_NOT_ALLOWED  = 2'd2,
        VERDICT_DEFAULT_DENY = 2'd3
    } verdict_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [HIT_W-1:0]  hit_rule;
    } result_t;

endpackage

>>> rtl/ip_cidr_access_check.sv
// Pipeline: an accepted input item is held in the input registers and its result in the result register.
// Throughput: one item per cycle while m_tready is high; the rule compare is a single
// pass over seven parallel prefix comparators between the input and result registers.
// Reset: rst_n clears the valid flags, the security mode and all rule words.
// ----------------------------------------------------------------------------
// IP CIDR access check
// Checks a client IPv4 address and connection class against configured
// allow and deny prefix rules and returns a verdict with the matching rule.
// ----------------------------------------------------------------------------
`include "ip_cidr_access_check_macros.svh"

module ip_cidr_access_check
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ipacl_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] client_ip
    input  logic [ipacl_pkg::IN_USER_W-1:0]     s_tuser,   // [1:0] conn_class

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipacl_pkg::OUT_DATA_W-1:0]    m_tdata,   // [1:0] verdict, [4:2] hit_rule

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipacl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipacl_pkg::RULE_W-1:0]        cfg_data
);

    logic [ipacl_pkg::MODE_W-1:0]   mode_reg;
    logic [ipacl_pkg::RULE_W-1:0]   rule_reg [ipacl_pkg::RULE_WORDS];

    logic                           in_valid_reg;
    logic [ipacl_pkg::ADDR_W-1:0]   ip_reg;
    logic [ipacl_pkg::CLASS_W-1:0]  class_reg;

    logic                           out_valid_reg;
    ipacl_pkg::result_t             result_reg;
    ipacl_pkg::result_t             result_next;

    logic                           out_load;
    logic                           in_load;

    logic [ipacl_pkg::RULES-1:0]    deny_hit;
    logic [ipacl_pkg::RULES-1:0]    allow_hit;
    logic [ipacl_pkg::RULES-1:0]    is_allow;
    logic [ipacl_pkg::RULES-1:0]    is_deny;
    logic [ipacl_pkg::HIT_W-1:0]    deny_idx;
    logic [ipacl_pkg::HIT_W-1:0]    allow_idx;

    assign cfg_ready = 1'b1;
    assign out_load  = !out_valid_reg || m_tready;
    assign in_load   = !in_valid_reg || out_load;
    assign s_tready  = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            for (int i = 0; i < ipacl_pkg::RULE_WORDS; i++)
            begin
                rule_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ipacl_pkg::CFG_SECURITY_MODE)
            begin
                mode_reg <= cfg_data[ipacl_pkg::MODE_W-1:0];
            end
            for (int i = 0; i < ipacl_pkg::RULE_WORDS; i++)
            begin
                if (cfg_index == ipacl_pkg::CFG_RULE_BASE + ipacl_pkg::CFG_IDX_W'(i))
                begin
                    rule_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && s_tvalid)
        begin
            ip_reg    <= s_tdata[ipacl_pkg::ADDR_W-1:0];
            class_reg <= s_tuser[ipacl_pkg::CLASS_W-1:0];
        end
        if (out_load && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        logic [ipacl_pkg::RULE_W-1:0]  w;
        logic [ipacl_pkg::PLEN_W-1:0]  plen;
        logic [1:0]                    dir;
        logic [1:0]                    kind;
        logic [ipacl_pkg::ADDR_W-1:0]  mask;
        logic                          dir_ok;
        logic                          addr_ok;

        for (int i = 0; i < ipacl_pkg::RULES; i++)
        begin
            w    = rule_reg[i];
            plen = w[ipacl_pkg::PLEN_LSB +: ipacl_pkg::PLEN_W];
            dir  = w[ipacl_pkg::DIR_LSB +: 2];
            kind = w[ipacl_pkg::KIND_LSB +: 2];
            if (plen >= ipacl_pkg::PLEN_W'(ipacl_pkg::ADDR_W))
            begin
                mask = '1;
            end
            else
            begin
                mask = ~({ipacl_pkg::ADDR_W{1'b1}} >> plen);
            end
            case (ipacl_pkg::conn_class_t'(class_reg))
                ipacl_pkg::CLASS_PLAY:    dir_ok = (dir == ipacl_pkg::DIR_PLAY);
                ipacl_pkg::CLASS_PUBLISH: dir_ok = (dir == ipacl_pkg::DIR_PUBLISH);
                default:                  dir_ok = 1'b0;
            endcase
            addr_ok = (((w[ipacl_pkg::ADDR_LSB +: ipacl_pkg::ADDR_W] ^ ip_reg) & mask) == '0);
            is_allow[i]  = (kind == ipacl_pkg::KIND_ALLOW);
            is_deny[i]   = (kind == ipacl_pkg::KIND_DENY);
            allow_hit[i] = is_allow[i] && dir_ok && addr_ok;
            deny_hit[i]  = is_deny[i] && dir_ok && addr_ok;
        end

        deny_idx  = ipacl_pkg::NO_HIT;
        allow_idx = ipacl_pkg::NO_HIT;
        for (int i = ipacl_pkg::RULES - 1; i >= 0; i--)
        begin
            if (deny_hit[i])
            begin
                deny_idx = ipacl_pkg::HIT_W'(i);
            end
            if (allow_hit[i])
            begin
                allow_idx = ipacl_pkg::HIT_W'(i);
            end
        end

        result_next.hit_rule = ipacl_pkg::NO_HIT;
        case (ipacl_pkg::sec_mode_t'(mode_reg))
            ipacl_pkg::MODE_DISABLED:
            begin
                result_next.verdict = ipacl_pkg::VERDICT_ALLOW;
            end
            ipacl_pkg::MODE_NO_RULES:
            begin
                result_next.verdict = ipacl_pkg::VERDICT_DEFAULT_DENY;
            end
            default:
            begin
                if (|deny_hit)
                begin
                    result_next.verdict  = ipacl_pkg::VERDICT_DENY_RULE;
                    result_next.hit_rule = deny_idx;
                end
                else if (|allow_hit)
                begin
                    result_next.verdict  = ipacl_pkg::VERDICT_ALLOW;
                    result_next.hit_rule = allow_idx;
                end
                else if ((|is_allow) || !(|is_deny))
                begin
                    result_next.verdict = ipacl_pkg::VERDICT_NOT_ALLOWED;
                end
                else
                begin
                    result_next.verdict = ipacl_pkg::VERDICT_ALLOW;
                end
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ipacl_pkg::OUT_DATA_W - ipacl_pkg::VERDICT_W - ipacl_pkg::HIT_W){1'b0}},
                       result_reg.hit_rule, result_reg.verdict};

    `IPACL_ASSERT_SAME(a_deny_has_hit,
        out_valid_reg && (result_reg.verdict == ipacl_pkg::VERDICT_DENY_RULE),
        result_reg.hit_rule != ipacl_pkg::NO_HIT,
        "deny verdict without a matching rule")
    `IPACL_ASSERT_SAME(a_default_no_hit,
        out_valid_reg && ((result_reg.verdict == ipacl_pkg::VERDICT_DEFAULT_DENY) ||
                          (result_reg.verdict == ipacl_pkg::VERDICT_NOT_ALLOWED)),
        result_reg.hit_rule == ipacl_pkg::NO_HIT,
        "refusal without a rule match reports a rule")
    `IPACL_ASSERT_NEXT(a_item_advances,
        in_valid_reg && out_load,
        out_valid_reg,
        "registered item did not reach the result register")

endmodule
